// ===== hdl/mdcs_pkg.sv =====
package mdcs_pkg;

    // Fixed field widths of the channels and registers.
    localparam int COUNT_W    = 16;
    localparam int LEVEL_W    = 10;
    localparam int CHAN_W     = 2;
    localparam int OUT_W      = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic [COUNT_W-1:0] ZERO_LIMIT_RST = 16'd10;
    localparam logic [COUNT_W-1:0] OVER_LIMIT_RST = 16'd10;
    localparam logic [LEVEL_W-1:0] CUTOFF_RST     = 10'd512;

    // Item kinds.
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;

    // One counter memory entry per channel.
    typedef struct packed {
        count_t zero_cnt;
        count_t over_cnt;
    } counts_t;

    // Register word index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_ZERO_LIMIT = 2'd0,
        REG_OVER_LIMIT = 2'd1,
        REG_CUTOFF     = 2'd2
    } reg_idx_t;

    // Saturating increment, holds at all ones.
    function automatic count_t sat_inc(count_t v);
        count_t r;
        if (v == '1)
        begin
            r = v;
        end
        else
        begin
            r = count_t'(v + count_t'(1));
        end
        return r;
    endfunction

endpackage

// ===== hdl/mdcs_if.sv =====
// Input channel: one start or sample beat.
interface mdcs_in_if #(parameter int SAMPLE_BITS = 10);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic                          direction;
    logic [mdcs_pkg::CHAN_W-1:0]   channel;
    logic [SAMPLE_BITS-1:0]        reading;

    modport source (output valid, action, direction, channel, reading, input ready);
    modport sink   (input valid, action, direction, channel, reading, output ready);
endinterface

// Output channel: pin and running state after each item.
interface mdcs_out_if;
    logic                        valid;
    logic                        ready;
    logic [mdcs_pkg::OUT_W-1:0]  running_mask;
    logic [mdcs_pkg::OUT_W-1:0]  drive_a;
    logic [mdcs_pkg::OUT_W-1:0]  drive_b;
    logic                        cut_now;

    modport source (output valid, running_mask, drive_a, drive_b, cut_now, input ready);
    modport sink   (input valid, running_mask, drive_a, drive_b, cut_now, output ready);
endinterface

// ===== hdl/mdcs_ram.sv =====
module mdcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/motor_draw_cutoff_supervisor_top.sv =====
// Current-draw supervisor for a set of H-bridge motor channels.
// Input beats arrive on in_ch: a start beat (action 0) clears all counters,
// marks every channel running and drives A/B for the given direction; a
// sample beat (action 1) updates the counters of its channel and may cut it.
// Every input beat yields exactly one output beat on out_ch with the running
// mask, both pin sets and a flag telling whether this beat cut its channel.
// Limits and the cutoff level are set through the APB port at 0x0, 0x4, 0x8.
// An input beat is registered in the update stage, its result in the output
// register. Throughput: one beat per cycle unless out_ch stalls, set by the
// per-channel counters, read at acceptance, written back as the stage advances,
// with a one-entry bypass for back-to-back samples on one channel.
// After reset all channels are stopped, pins are low, counters read as zero
// and the registers hold their defaults (10, 10, 512).
// When the receiver stalls the finished result waits in the output register,
// one more beat is held in the update stage, and in_ch.ready then drops.
module motor_draw_cutoff_supervisor_top #(
    parameter int NUM_CHANNELS = 3,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mdcs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mdcs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mdcs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    mdcs_in_if.sink                             in_ch,
    mdcs_out_if.source                          out_ch
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W = NUM_CHANNELS + mdcs_pkg::OUT_W;
    localparam int CNT_W = 2 * mdcs_pkg::COUNT_W;

    // Configuration registers.
    mdcs_pkg::count_t                 zero_limit_reg;
    mdcs_pkg::count_t                 over_limit_reg;
    logic [mdcs_pkg::LEVEL_W-1:0]     cutoff_reg;
    logic                             cfg_wr;
    mdcs_pkg::reg_idx_t               cfg_idx;

    // Update stage.
    logic                             s2_valid_reg, s2_valid_next;
    logic                             s2_action_reg;
    logic                             s2_dir_reg;
    logic                             s2_inrange_reg;
    logic [IDX_W-1:0]                 s2_idx_reg;
    logic                             s2_is_zero_reg;
    logic                             s2_is_over_reg;
    logic                             s2_fwd_hit_reg;
    mdcs_pkg::counts_t                fwd_data_reg;
    logic                             s2_adv;
    logic                             s2_active;

    // Input side.
    logic                             in_acc;
    logic                             in_inrange;
    logic [IDX_W-1:0]                 rd_idx;

    // Channel state.
    logic [NUM_CHANNELS-1:0]          running_reg, running_next;
    logic [NUM_CHANNELS-1:0]          drive_a_reg, drive_a_next;
    logic [NUM_CHANNELS-1:0]          drive_b_reg, drive_b_next;
    logic [NUM_CHANNELS-1:0]          valid_reg, valid_next;
    logic [NUM_CHANNELS-1:0]          chan_bit;

    // Counter memory access.
    logic [CNT_W-1:0]                 ram_rdata;
    mdcs_pkg::counts_t                base_cnt;
    mdcs_pkg::counts_t                wr_data;
    logic                             wr_en;
    logic                             stop;

    // Output register.
    logic                             out_valid_reg;
    logic [mdcs_pkg::OUT_W-1:0]       out_running_reg;
    logic [mdcs_pkg::OUT_W-1:0]       out_a_reg;
    logic [mdcs_pkg::OUT_W-1:0]       out_b_reg;
    logic                             out_cut_reg;
    logic [EXT_W-1:0]                 run_ext;
    logic [EXT_W-1:0]                 a_ext;
    logic [EXT_W-1:0]                 b_ext;

    // APB register file; every access completes in its access cycle.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = mdcs_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_limit_reg <= mdcs_pkg::ZERO_LIMIT_RST;
            over_limit_reg <= mdcs_pkg::OVER_LIMIT_RST;
            cutoff_reg     <= mdcs_pkg::CUTOFF_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                mdcs_pkg::REG_ZERO_LIMIT: zero_limit_reg <= pwdata[mdcs_pkg::COUNT_W-1:0];
                mdcs_pkg::REG_OVER_LIMIT: over_limit_reg <= pwdata[mdcs_pkg::COUNT_W-1:0];
                mdcs_pkg::REG_CUTOFF:     cutoff_reg     <= pwdata[mdcs_pkg::LEVEL_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (cfg_idx)
            mdcs_pkg::REG_ZERO_LIMIT:
                prdata = mdcs_pkg::CFG_DATA_W'(zero_limit_reg);
            mdcs_pkg::REG_OVER_LIMIT:
                prdata = mdcs_pkg::CFG_DATA_W'(over_limit_reg);
            mdcs_pkg::REG_CUTOFF:
                prdata = mdcs_pkg::CFG_DATA_W'(cutoff_reg);
            default:
                prdata = '0;
        endcase
    end

    // Handshake: the update stage moves on whenever the output register is free.
    assign s2_adv      = s2_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s2_valid_reg || s2_adv;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign in_inrange  = 32'(in_ch.channel) < NUM_CHANNELS;
    assign rd_idx      = in_inrange ? IDX_W'(in_ch.channel) : '0;

    // Counter memory, one entry per channel.
    mdcs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_CHANNELS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s2_idx_reg),
        .wdata (wr_data),
        .re    (in_acc),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // Stage valid.
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (in_acc)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage payload, with the bypass of a write-back at the same edge.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s2_action_reg  <= in_ch.action;
            s2_dir_reg     <= in_ch.direction;
            s2_inrange_reg <= in_inrange;
            s2_idx_reg     <= rd_idx;
            s2_is_zero_reg <= (in_ch.reading[SAMPLE_BITS-1:0] == '0);
            s2_is_over_reg <= 32'(in_ch.reading[SAMPLE_BITS-1:0]) >= 32'(cutoff_reg);
            s2_fwd_hit_reg <= wr_en && (s2_idx_reg == rd_idx);
            fwd_data_reg   <= wr_data;
        end
    end

    // Counter values seen by this sample; an unwritten entry since start is zero.
    always_comb
    begin
        if (s2_fwd_hit_reg)
        begin
            base_cnt = fwd_data_reg;
        end
        else if (valid_reg[s2_idx_reg])
        begin
            base_cnt = mdcs_pkg::counts_t'(ram_rdata);
        end
        else
        begin
            base_cnt = '0;
        end
    end

    assign s2_active = (s2_action_reg == mdcs_pkg::ACT_SAMPLE) && s2_inrange_reg
                       && running_reg[s2_idx_reg];

    // Counter update and cut decision.
    always_comb
    begin
        wr_data = base_cnt;
        stop    = 1'b0;
        if (s2_is_zero_reg)
        begin
            wr_data.zero_cnt = mdcs_pkg::sat_inc(base_cnt.zero_cnt);
            wr_data.over_cnt = '0;
        end
        if (wr_data.zero_cnt > zero_limit_reg)
        begin
            stop = 1'b1;
        end
        if (s2_is_over_reg)
        begin
            if (wr_data.over_cnt > over_limit_reg)
            begin
                stop = 1'b1;
            end
            else
            begin
                wr_data.over_cnt = mdcs_pkg::sat_inc(wr_data.over_cnt);
            end
        end
    end

    assign wr_en    = s2_adv && s2_active;
    assign chan_bit = NUM_CHANNELS'(1) << s2_idx_reg;

    // Channel state next values.
    always_comb
    begin
        running_next = running_reg;
        drive_a_next = drive_a_reg;
        drive_b_next = drive_b_reg;
        valid_next   = valid_reg;
        if (s2_adv)
        begin
            if (s2_action_reg == mdcs_pkg::ACT_START)
            begin
                running_next = '1;
                drive_a_next = s2_dir_reg ? '1 : '0;
                drive_b_next = s2_dir_reg ? '0 : '1;
                valid_next   = '0;
            end
            else if (s2_active)
            begin
                valid_next = valid_reg | chan_bit;
                if (stop)
                begin
                    running_next = running_reg & ~chan_bit;
                    drive_a_next = drive_a_reg & ~chan_bit;
                    drive_b_next = drive_b_reg & ~chan_bit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            drive_a_reg <= '0;
            drive_b_reg <= '0;
            valid_reg   <= '0;
        end
        else
        begin
            running_reg <= running_next;
            drive_a_reg <= drive_a_next;
            drive_b_reg <= drive_b_next;
            valid_reg   <= valid_next;
        end
    end

    // Result beat: low channels of the state after the item.
    assign run_ext = {{mdcs_pkg::OUT_W{1'b0}}, running_next};
    assign a_ext   = {{mdcs_pkg::OUT_W{1'b0}}, drive_a_next};
    assign b_ext   = {{mdcs_pkg::OUT_W{1'b0}}, drive_b_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_running_reg <= run_ext[mdcs_pkg::OUT_W-1:0];
            out_a_reg       <= a_ext[mdcs_pkg::OUT_W-1:0];
            out_b_reg       <= b_ext[mdcs_pkg::OUT_W-1:0];
            out_cut_reg     <= s2_active && stop;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.running_mask = out_running_reg;
    assign out_ch.drive_a      = out_a_reg;
    assign out_ch.drive_b      = out_b_reg;
    assign out_ch.cut_now      = out_cut_reg;

    // A start that completes leaves every channel running.
    a_start_runs_all: assert property (
        @(posedge clk) disable iff (!rst_n)
        s2_adv && (s2_action_reg == mdcs_pkg::ACT_START) |=> running_reg == '1
    ) else $error("start did not set all channels running");

    // A bridge never has both inputs high.
    a_no_shoot_through: assert property (
        @(posedge clk) disable iff (!rst_n)
        (drive_a_reg & drive_b_reg) == '0
    ) else $error("both bridge inputs high on a channel");

    // Pins are driven only on running channels.
    a_drive_only_running: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((drive_a_reg | drive_b_reg) & ~running_reg) == '0
    ) else $error("pin driven on a stopped channel");

    // A cut clears the running bit of its channel.
    a_cut_clears_bit: assert property (
        @(posedge clk) disable iff (!rst_n)
        wr_en && stop |=> running_reg[$past(s2_idx_reg)] == 1'b0
    ) else $error("cut channel still marked running");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_MOTORS  = 3;
    localparam int READING_W   = 10;
    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic                          action;
        logic                          direction;
        logic [mdcs_pkg::CHAN_W-1:0]   channel;
        logic [READING_W-1:0]          reading;
    } draw_item_t;

    typedef struct packed {
        logic [mdcs_pkg::OUT_W-1:0] running_mask;
        logic [mdcs_pkg::OUT_W-1:0] drive_a;
        logic [mdcs_pkg::OUT_W-1:0] drive_b;
        logic                       cut_now;
    } drive_state_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [mdcs_pkg::CFG_ADDR_W-1:0] paddr;
    logic [mdcs_pkg::CFG_DATA_W-1:0] pwdata;
    logic [mdcs_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    mdcs_in_if #(.SAMPLE_BITS(READING_W)) in_ch ();
    mdcs_out_if                           out_ch ();

    motor_draw_cutoff_supervisor_top #(
        .NUM_CHANNELS(NUM_MOTORS),
        .SAMPLE_BITS (READING_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Pending stimulus and the pin states still owed by the block.
    draw_item_t   item_backlog[$];
    drive_state_t expected_states[$];

    // Register copies used by the predictor.
    mdcs_pkg::count_t               zero_limit;
    mdcs_pkg::count_t               over_limit;
    logic [mdcs_pkg::LEVEL_W-1:0]   cutoff_lvl;

    // Predicted supervisor state.
    logic [mdcs_pkg::OUT_W-1:0] run_bits;
    logic [mdcs_pkg::OUT_W-1:0] pin_a;
    logic [mdcs_pkg::OUT_W-1:0] pin_b;
    mdcs_pkg::count_t           zero_cnt[NUM_MOTORS];
    mdcs_pkg::count_t           over_cnt[NUM_MOTORS];

    int   error_count;
    int   stuck_cycles;
    int   src_gap;
    int   snk_gap;
    bit   calm;
    logic in_beat_taken;

    always #2 clk = ~clk;

    function automatic mdcs_pkg::count_t bump_count(mdcs_pkg::count_t v);
        return (v == '1) ? v : mdcs_pkg::count_t'(v + 1'b1);
    endfunction

    function automatic void note_mismatch(string what);
        error_count++;
        if (error_count <= 10)
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endfunction

    // Advances the predicted state by one beat and returns the pin state after it.
    function automatic drive_state_t apply_draw_item(draw_item_t it);
        drive_state_t r;
        logic         cut;
        int           ch;
        cut = 1'b0;
        ch  = int'(it.channel);
        if (it.action == mdcs_pkg::ACT_START)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                zero_cnt[i] = '0;
                over_cnt[i] = '0;
            end
            pin_a    = it.direction ? '1 : '0;
            pin_b    = it.direction ? '0 : '1;
            run_bits = '1;
        end
        else if (ch < NUM_MOTORS && run_bits[ch])
        begin
            if (it.reading == '0)
            begin
                zero_cnt[ch] = bump_count(zero_cnt[ch]);
                over_cnt[ch] = '0;
            end
            if (zero_cnt[ch] > zero_limit)
            begin
                cut = 1'b1;
            end
            // With a zero cutoff a zero reading also goes through this check.
            if (it.reading >= cutoff_lvl)
            begin
                if (over_cnt[ch] > over_limit)
                begin
                    cut = 1'b1;
                end
                else
                begin
                    over_cnt[ch] = bump_count(over_cnt[ch]);
                end
            end
            if (cut)
            begin
                run_bits[ch] = 1'b0;
                pin_a[ch]    = 1'b0;
                pin_b[ch]    = 1'b0;
            end
        end
        r.running_mask = run_bits;
        r.drive_a      = pin_a;
        r.drive_b      = pin_b;
        r.cut_now      = cut;
        return r;
    endfunction

    function automatic draw_item_t make_item(logic act, logic dir,
                                             logic [mdcs_pkg::CHAN_W-1:0] ch,
                                             logic [READING_W-1:0] rd);
        draw_item_t it;
        it.action    = act;
        it.direction = dir;
        it.channel   = ch;
        it.reading   = rd;
        return it;
    endfunction

    // Mostly samples on live channels, biased toward zero and over-level readings.
    function automatic draw_item_t random_item(logic [mdcs_pkg::LEVEL_W-1:0] level);
        draw_item_t it;
        int         pick;
        it.action    = mdcs_pkg::ACT_SAMPLE;
        it.direction = 1'($urandom_range(0, 1));
        it.channel   = ($urandom_range(0, 19) == 0) ? 2'd3
                                                     : mdcs_pkg::CHAN_W'($urandom_range(0, 2));
        pick         = $urandom_range(0, 99);
        if (pick < 25)
        begin
            it.reading = '0;
        end
        else if (pick < 60)
        begin
            it.reading = READING_W'($urandom_range(int'(level), 1023));
        end
        else
        begin
            it.reading = READING_W'($urandom);
        end
        if ($urandom_range(0, 99) < 4)
        begin
            it.action = mdcs_pkg::ACT_START;
        end
        return it;
    endfunction

    // One APB write followed by a checked read-back of the same register.
    task automatic set_register(mdcs_pkg::reg_idx_t idx,
                                logic [mdcs_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = mdcs_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        case (idx)
            mdcs_pkg::REG_ZERO_LIMIT: zero_limit = mdcs_pkg::count_t'(value);
            mdcs_pkg::REG_OVER_LIMIT: over_limit = mdcs_pkg::count_t'(value);
            mdcs_pkg::REG_CUTOFF:     cutoff_lvl = mdcs_pkg::LEVEL_W'(value);
            default:                  ;
        endcase
        @(negedge clk);
        psel   = 1'b1;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
        begin
            note_mismatch($sformatf("register %s read back 0x%0h, expected 0x%0h",
                                    idx.name(), prdata, value));
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_limits(int zl, int ol, int cl);
        set_register(mdcs_pkg::REG_ZERO_LIMIT, mdcs_pkg::CFG_DATA_W'(zl));
        set_register(mdcs_pkg::REG_OVER_LIMIT, mdcs_pkg::CFG_DATA_W'(ol));
        set_register(mdcs_pkg::REG_CUTOFF, mdcs_pkg::CFG_DATA_W'(cl));
    endtask

    // Waits until every queued beat went in and every result came back.
    task automatic wait_drained();
        while (item_backlog.size() != 0 || in_ch.valid === 1'b1 ||
               expected_states.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random_phase(int zl, int ol, int cl, bit quiet);
        calm = quiet;
        set_limits(zl, ol, cl);
        item_backlog.push_back(make_item(mdcs_pkg::ACT_START, 1'($urandom_range(0, 1)),
                                         '0, '0));
        repeat (84) item_backlog.push_back(random_item(mdcs_pkg::LEVEL_W'(cl)));
        wait_drained();
    endtask

    // Input acceptance: the predictor runs on each accepted beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_beat_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_states.push_back(apply_draw_item(make_item(
                    in_ch.action, in_ch.direction, in_ch.channel, in_ch.reading)));
            end
        end
    end

    // Input driver with random gaps between beats.
    always @(negedge clk)
    begin : drive_in
        draw_item_t nxt;
        if (rst_n && (!in_ch.valid || in_beat_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap     <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                src_gap     <= $urandom_range(0, 7);
                in_ch.valid <= 1'b0;
            end
            else if (item_backlog.size() != 0)
            begin
                nxt = item_backlog.pop_front();
                in_ch.action    <= nxt.action;
                in_ch.direction <= nxt.direction;
                in_ch.channel   <= nxt.channel;
                in_ch.reading   <= nxt.reading;
                in_ch.valid     <= 1'b1;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output ready with random stall bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (snk_gap > 0)
            begin
                snk_gap      <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                snk_gap      <= $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Output monitor: each beat against the oldest expectation.
    always @(posedge clk)
    begin : watch_out
        drive_state_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_states.size() == 0)
            begin
                note_mismatch("output beat with no expectation pending");
            end
            else
            begin
                want = expected_states.pop_front();
                if (out_ch.running_mask !== want.running_mask)
                begin
                    note_mismatch($sformatf("running_mask %b, expected %b",
                                            out_ch.running_mask, want.running_mask));
                end
                if (out_ch.drive_a !== want.drive_a)
                begin
                    note_mismatch($sformatf("drive_a %b, expected %b",
                                            out_ch.drive_a, want.drive_a));
                end
                if (out_ch.drive_b !== want.drive_b)
                begin
                    note_mismatch($sformatf("drive_b %b, expected %b",
                                            out_ch.drive_b, want.drive_b));
                end
                if (out_ch.cut_now !== want.cut_now)
                begin
                    note_mismatch($sformatf("cut_now %b, expected %b",
                                            out_ch.cut_now, want.cut_now));
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.action    = mdcs_pkg::ACT_START;
        in_ch.direction = 1'b0;
        in_ch.channel   = '0;
        in_ch.reading   = '0;
        out_ch.ready    = 1'b0;
        in_beat_taken   = 1'b0;
        error_count     = 0;
        stuck_cycles    = 0;
        src_gap         = 0;
        snk_gap         = 0;
        calm            = 1'b0;
        zero_limit      = mdcs_pkg::ZERO_LIMIT_RST;
        over_limit      = mdcs_pkg::OVER_LIMIT_RST;
        cutoff_lvl      = mdcs_pkg::CUTOFF_RST;
        run_bits        = '0;
        pin_a           = '0;
        pin_b           = '0;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            zero_cnt[i] = '0;
            over_cnt[i] = '0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset limits: stopped channel, ignored start fields, channel out of range,
        // readings just under and at the cutoff.
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd0, 10'd1023));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_START,  1'b1, 2'd3, 10'd1023));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b1, 2'd3, 10'd1023));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd0, 10'd511));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd0, 10'd512));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd1, 10'd0));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd2, 10'd1023));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_START,  1'b0, 2'd0, 10'd0));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b1, 2'd2, 10'd0));
        wait_drained();

        // Zero limits and zero cutoff: every channel is cut on its first excess.
        set_limits(0, 0, 0);
        item_backlog.push_back(make_item(mdcs_pkg::ACT_START,  1'b1, 2'd0, 10'd0));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd0, 10'd0));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd0, 10'd0));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd1, 10'd5));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd1, 10'd5));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd2, 10'd1023));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_SAMPLE, 1'b0, 2'd2, 10'd1023));
        item_backlog.push_back(make_item(mdcs_pkg::ACT_START,  1'b0, 2'd2, 10'd1023));
        wait_drained();

        // Random phases over several register settings; the last runs without idling.
        run_random_phase(3, 3, 512, 1'b0);
        run_random_phase(0, 0, 0, 1'b0);
        run_random_phase(65535, 65535, 1023, 1'b0);
        run_random_phase(1, 2, 1, 1'b0);
        run_random_phase($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 1023),
                         1'b0);
        run_random_phase($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 1023),
                         1'b1);

        repeat (4) @(posedge clk);
        if (expected_states.size() != 0)
        begin
            note_mismatch($sformatf("%0d expected beats never arrived",
                                    expected_states.size()));
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
